// File: src/tfn_pkg.sv
// shared types and constants for the triangle face normal block
package tfn_pkg;

	// opcodes of an input item
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FACE  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// result kinds
	localparam logic RK_FACE = 1'b0;
	localparam logic RK_READ = 1'b1;

	// fixed field widths
	localparam int IN_IDX_W = 12;
	localparam int POS_W    = 32;
	localparam int NRM_W    = 16;

	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_FACE,
		KIND_READ
	} kind_t;

	// one classified command, indices already reduced to the store depth
	typedef struct packed {
		kind_t                      kind;
		logic [IN_IDX_W-1:0]        vidx;
		logic [IN_IDX_W-1:0]        ca;
		logic [IN_IDX_W-1:0]        cb;
		logic [IN_IDX_W-1:0]        cc;
		logic signed [POS_W-1:0]    px;
		logic signed [POS_W-1:0]    py;
		logic signed [POS_W-1:0]    pz;
	} cmd_t;

	// queue head seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} fe_out_t;

	// back end status seen by the front end
	typedef struct packed {
		logic pop;
		logic clearing;
	} be_stat_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRPOS,
		ST_RDA,
		ST_RDB,
		ST_RDC,
		ST_DIFF,
		ST_MULA,
		ST_MULB,
		ST_SUB,
		ST_MAG,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_DIVL,
		ST_DIV,
		ST_WB,
		ST_RDN,
		ST_RDN2
	} be_state_t;

endpackage

// File: src/tfn_ram.sv
// generic single write, single read ram with registered read data
module tfn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/tfn_front.sv
// front end: takes commands, classifies them and queues them for the back end
module tfn_front #(
	parameter int VERTEX_DEPTH = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         opcode,
	input  logic [tfn_pkg::IN_IDX_W-1:0]       vertex_index,
	input  logic signed [tfn_pkg::POS_W-1:0]   pos_x,
	input  logic signed [tfn_pkg::POS_W-1:0]   pos_y,
	input  logic signed [tfn_pkg::POS_W-1:0]   pos_z,
	input  logic [tfn_pkg::IN_IDX_W-1:0]       corner_a,
	input  logic [tfn_pkg::IN_IDX_W-1:0]       corner_b,
	input  logic [tfn_pkg::IN_IDX_W-1:0]       corner_c,
	input  tfn_pkg::be_stat_t                  stat,
	output tfn_pkg::fe_out_t                   head
);

	tfn_pkg::cmd_t fifo_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          accept;
	logic          push;
	tfn_pkg::cmd_t cmd_new;

	// reduce an index modulo the store depth by restoring subtraction
	function automatic logic [tfn_pkg::IN_IDX_W-1:0] reduce_idx(
		input logic [tfn_pkg::IN_IDX_W-1:0] v
	);
		logic [31:0] r;
		logic [31:0] lim;
		r = 32'(v);
		for (int k = tfn_pkg::IN_IDX_W - 1; k >= 0; k--) begin
			lim = 32'(VERTEX_DEPTH) << k;
			if (r >= lim) begin
				r = r - lim;
			end
		end
		return r[tfn_pkg::IN_IDX_W-1:0];
	endfunction

	// transfer and classification
	assign busy   = (cnt_q == 2'd2) || stat.clearing;
	assign accept = start && !busy;

	always_comb begin
		cmd_new.vidx = reduce_idx(vertex_index);
		cmd_new.ca   = reduce_idx(corner_a);
		cmd_new.cb   = reduce_idx(corner_b);
		cmd_new.cc   = reduce_idx(corner_c);
		cmd_new.px   = pos_x;
		cmd_new.py   = pos_y;
		cmd_new.pz   = pos_z;
		push         = 1'b0;
		cmd_new.kind = tfn_pkg::KIND_WRITE;
		case (opcode)
			tfn_pkg::OP_WRITE: begin
				cmd_new.kind = tfn_pkg::KIND_WRITE;
				push         = accept;
			end
			tfn_pkg::OP_FACE: begin
				cmd_new.kind = tfn_pkg::KIND_FACE;
				push         = accept;
			end
			tfn_pkg::OP_READ: begin
				cmd_new.kind = tfn_pkg::KIND_READ;
				push         = accept;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= cmd_new;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (stat.pop) begin
				rp_q <= !rp_q;
			end
			if (push && !stat.pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && stat.pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = fifo_q[rp_q];

endmodule

// File: src/tfn_back.sv
// back end: position and normal stores, cross product, sqrt and divide sequencer
module tfn_back #(
	parameter int VERTEX_DEPTH     = 4096,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tfn_pkg::fe_out_t                  head,
	output tfn_pkg::be_stat_t                 stat,
	output logic                              done,
	output logic                              result_kind,
	output logic signed [tfn_pkg::NRM_W-1:0]  normal_x,
	output logic signed [tfn_pkg::NRM_W-1:0]  normal_y,
	output logic signed [tfn_pkg::NRM_W-1:0]  normal_z,
	output logic                              degenerate
);

	localparam int IDX_W = $clog2(VERTEX_DEPTH);
	localparam int QW    = NORMAL_FRAC_BITS + 3;
	localparam int LIM   = (NORMAL_FRAC_BITS >= 15) ? 32767 : (1 << NORMAL_FRAC_BITS);
	localparam int PW    = 3 * tfn_pkg::POS_W;
	localparam int NW    = 3 * tfn_pkg::NRM_W;

	tfn_pkg::be_state_t state_q, state_d;
	tfn_pkg::cmd_t      cmd_q;
	logic [1:0]         cnt_q;
	logic [5:0]         bit_q;
	logic [IDX_W-1:0]   clr_q;

	logic [PW-1:0]          v0_q, v1_q;
	logic signed [32:0]     d_q [3];
	logic signed [32:0]     e_q [3];
	logic signed [65:0]     p1_q;
	logic signed [66:0]     c_q [3];
	logic [66:0]            mag_q [3];
	logic                   neg_q [3];
	logic                   degen_q;
	logic [31:0]            acc_q;
	logic [63:0]            rad_q;
	logic [31:0]            root_q;
	logic [33:0]            srem_q;
	logic [31:0]            drem_q;
	logic [QW-1:0]          quo_q;
	logic [tfn_pkg::NRM_W-1:0] nrm_q [3];

	// ram ports
	logic              pos_we, pos_re, nrm_we, nrm_re;
	logic [IDX_W-1:0]  pos_waddr, pos_raddr, nrm_waddr, nrm_raddr;
	logic [PW-1:0]     pos_rdata;
	logic [NW-1:0]     nrm_wdata, nrm_rdata;
	logic              emit_face, emit_read;

	// combinational datapath helpers
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic [66:0]        orv;
	logic [14:0]        mm_sel;
	logic [29:0]        sq;
	logic [31:0]        acc_next;
	logic [35:0]        s_rem_n, s_try;
	logic               s_ge;
	logic [32:0]        d_rem2;
	logic               d_ge;
	logic [QW-1:0]      q_full;
	logic [QW:0]        q_inc;
	logic [QW-1:0]      q_rnd, q_clp;
	logic [tfn_pkg::NRM_W-1:0] q16;

	function automatic logic [IDX_W-1:0] to_addr(input logic [tfn_pkg::IN_IDX_W-1:0] v);
		logic [IDX_W+tfn_pkg::IN_IDX_W-1:0] t;
		t = {{IDX_W{1'b0}}, v};
		return t[IDX_W-1:0];
	endfunction

	function automatic logic signed [32:0] comp(input logic [PW-1:0] v, input int k);
		logic [31:0] w;
		w = v[PW-1-32*k -: 32];
		return {w[31], w};
	endfunction

	tfn_ram #(.WIDTH(PW), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (pos_waddr),
		.wdata ({cmd_q.px, cmd_q.py, cmd_q.pz}),
		.re    (pos_re),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	tfn_ram #(.WIDTH(NW), .DEPTH(VERTEX_DEPTH)) u_nrm_ram (
		.clk   (clk),
		.we    (nrm_we),
		.waddr (nrm_waddr),
		.wdata (nrm_wdata),
		.re    (nrm_re),
		.raddr (nrm_raddr),
		.rdata (nrm_rdata)
	);

	// shared multiplier operand select, one product per cycle
	always_comb begin
		mul_a = d_q[1];
		mul_b = e_q[2];
		case (cnt_q)
			2'd0: begin
				mul_a = (state_q == tfn_pkg::ST_MULA) ? d_q[1] : d_q[2];
				mul_b = (state_q == tfn_pkg::ST_MULA) ? e_q[2] : e_q[1];
			end
			2'd1: begin
				mul_a = (state_q == tfn_pkg::ST_MULA) ? d_q[2] : d_q[0];
				mul_b = (state_q == tfn_pkg::ST_MULA) ? e_q[0] : e_q[2];
			end
			2'd2: begin
				mul_a = (state_q == tfn_pkg::ST_MULA) ? d_q[0] : d_q[1];
				mul_b = (state_q == tfn_pkg::ST_MULA) ? e_q[1] : e_q[0];
			end
			default: begin
				mul_a = d_q[1];
				mul_b = e_q[2];
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// magnitude scan, squares, sqrt step and divide step
	always_comb begin
		orv      = mag_q[0] | mag_q[1] | mag_q[2];
		mm_sel   = mag_q[cnt_q][14:0];
		sq       = mm_sel * mm_sel;
		acc_next = acc_q + 32'(sq);
		s_rem_n  = {srem_q, rad_q[63:62]};
		s_try    = {2'b00, root_q, 2'b01};
		s_ge     = (s_rem_n >= s_try);
		d_rem2   = {drem_q, 1'b0};
		d_ge     = (d_rem2 >= {1'b0, root_q});
		q_full   = {quo_q[QW-2:0], d_ge};
		q_inc    = {1'b0, q_full} + {{QW{1'b0}}, 1'b1};
		q_rnd    = q_inc[QW:1];
		q_clp    = (q_rnd > QW'(LIM)) ? QW'(LIM) : q_rnd;
		q16      = 16'(q_clp);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tfn_pkg::ST_CLEAR: begin
				if (clr_q == IDX_W'(VERTEX_DEPTH - 1)) begin
					state_d = tfn_pkg::ST_IDLE;
				end
			end
			tfn_pkg::ST_IDLE: begin
				if (head.valid) begin
					case (head.cmd.kind)
						tfn_pkg::KIND_WRITE: state_d = tfn_pkg::ST_WRPOS;
						tfn_pkg::KIND_FACE:  state_d = tfn_pkg::ST_RDA;
						tfn_pkg::KIND_READ:  state_d = tfn_pkg::ST_RDN;
						default:             state_d = tfn_pkg::ST_IDLE;
					endcase
				end
			end
			tfn_pkg::ST_WRPOS: state_d = tfn_pkg::ST_IDLE;
			tfn_pkg::ST_RDA:   state_d = tfn_pkg::ST_RDB;
			tfn_pkg::ST_RDB:   state_d = tfn_pkg::ST_RDC;
			tfn_pkg::ST_RDC:   state_d = tfn_pkg::ST_DIFF;
			tfn_pkg::ST_DIFF:  state_d = tfn_pkg::ST_MULA;
			tfn_pkg::ST_MULA:  state_d = tfn_pkg::ST_MULB;
			tfn_pkg::ST_MULB:  state_d = tfn_pkg::ST_SUB;
			tfn_pkg::ST_SUB: begin
				state_d = (cnt_q == 2'd2) ? tfn_pkg::ST_MAG : tfn_pkg::ST_MULA;
			end
			tfn_pkg::ST_MAG: state_d = tfn_pkg::ST_NORM;
			tfn_pkg::ST_NORM: begin
				if (orv == '0) begin
					state_d = tfn_pkg::ST_WB;
				end else if (orv[66:15] == '0) begin
					state_d = tfn_pkg::ST_SQ;
				end
			end
			tfn_pkg::ST_SQ: begin
				if (cnt_q == 2'd2) begin
					state_d = tfn_pkg::ST_SQRT;
				end
			end
			tfn_pkg::ST_SQRT: begin
				if (bit_q == 6'd1) begin
					state_d = tfn_pkg::ST_DIVL;
				end
			end
			tfn_pkg::ST_DIVL: state_d = tfn_pkg::ST_DIV;
			tfn_pkg::ST_DIV: begin
				if (bit_q == 6'd1) begin
					state_d = (cnt_q == 2'd2) ? tfn_pkg::ST_WB : tfn_pkg::ST_DIVL;
				end
			end
			tfn_pkg::ST_WB: begin
				if (cnt_q == 2'd2) begin
					state_d = tfn_pkg::ST_IDLE;
				end
			end
			tfn_pkg::ST_RDN:  state_d = tfn_pkg::ST_RDN2;
			tfn_pkg::ST_RDN2: state_d = tfn_pkg::ST_IDLE;
			default:          state_d = tfn_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: ram controls, pop and result strobes
	always_comb begin
		pos_we        = 1'b0;
		pos_re        = 1'b0;
		pos_waddr     = to_addr(cmd_q.vidx);
		pos_raddr     = to_addr(cmd_q.ca);
		nrm_we        = 1'b0;
		nrm_re        = 1'b0;
		nrm_waddr     = clr_q;
		nrm_wdata     = '0;
		nrm_raddr     = to_addr(cmd_q.vidx);
		stat.pop      = 1'b0;
		stat.clearing = 1'b0;
		emit_face     = 1'b0;
		emit_read     = 1'b0;
		case (state_q)
			tfn_pkg::ST_CLEAR: begin
				stat.clearing = 1'b1;
				nrm_we        = 1'b1;
			end
			tfn_pkg::ST_IDLE: stat.pop = head.valid;
			tfn_pkg::ST_WRPOS: pos_we = 1'b1;
			tfn_pkg::ST_RDA: begin
				pos_re    = 1'b1;
				pos_raddr = to_addr(cmd_q.ca);
			end
			tfn_pkg::ST_RDB: begin
				pos_re    = 1'b1;
				pos_raddr = to_addr(cmd_q.cb);
			end
			tfn_pkg::ST_RDC: begin
				pos_re    = 1'b1;
				pos_raddr = to_addr(cmd_q.cc);
			end
			tfn_pkg::ST_WB: begin
				nrm_we    = 1'b1;
				nrm_wdata = {nrm_q[0], nrm_q[1], nrm_q[2]};
				case (cnt_q)
					2'd0:    nrm_waddr = to_addr(cmd_q.ca);
					2'd1:    nrm_waddr = to_addr(cmd_q.cb);
					default: nrm_waddr = to_addr(cmd_q.cc);
				endcase
				emit_face = (cnt_q == 2'd2);
			end
			tfn_pkg::ST_RDN: nrm_re = 1'b1;
			tfn_pkg::ST_RDN2: emit_read = 1'b1;
			default: begin
				pos_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfn_pkg::ST_CLEAR;
			cnt_q   <= 2'd0;
			bit_q   <= 6'd0;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= emit_face || emit_read;
			case (state_q)
				tfn_pkg::ST_CLEAR: clr_q <= clr_q + IDX_W'(1);
				tfn_pkg::ST_IDLE:  cnt_q <= 2'd0;
				tfn_pkg::ST_SUB: begin
					cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
				end
				tfn_pkg::ST_NORM: cnt_q <= 2'd0;
				tfn_pkg::ST_SQ: begin
					if (cnt_q == 2'd2) begin
						cnt_q <= 2'd0;
						bit_q <= 6'd32;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				tfn_pkg::ST_SQRT: bit_q <= bit_q - 6'd1;
				tfn_pkg::ST_DIVL: bit_q <= 6'(QW);
				tfn_pkg::ST_DIV: begin
					bit_q <= bit_q - 6'd1;
					if (bit_q == 6'd1) begin
						cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
					end
				end
				tfn_pkg::ST_WB: cnt_q <= cnt_q + 2'd1;
				default: begin
					bit_q <= bit_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit_read) begin
			result_kind <= tfn_pkg::RK_READ;
			normal_x    <= nrm_rdata[NW-1 -: 16];
			normal_y    <= nrm_rdata[NW-17 -: 16];
			normal_z    <= nrm_rdata[15:0];
			degenerate  <= 1'b0;
		end else if (emit_face) begin
			result_kind <= tfn_pkg::RK_FACE;
			normal_x    <= nrm_q[0];
			normal_y    <= nrm_q[1];
			normal_z    <= nrm_q[2];
			degenerate  <= degen_q;
		end
		// corner a arrives while b is read, corner b while c is read
		case (state_q)
			tfn_pkg::ST_IDLE: cmd_q <= head.cmd;
			tfn_pkg::ST_RDB:  v0_q  <= pos_rdata;
			tfn_pkg::ST_RDC:  v1_q  <= pos_rdata;
			default: begin
				v0_q <= v0_q;
			end
		endcase
		case (state_q)
			tfn_pkg::ST_MULA: p1_q <= mul_p;
			tfn_pkg::ST_SUB: c_q[cnt_q] <= 67'(p1_q) - 67'(mul_p);
			tfn_pkg::ST_MAG: begin
				degen_q <= 1'b0;
				for (int k = 0; k < 3; k++) begin
					neg_q[k] <= c_q[k][66];
					mag_q[k] <= c_q[k][66] ? 67'(-c_q[k]) : 67'(c_q[k]);
				end
			end
			tfn_pkg::ST_NORM: begin
				acc_q <= '0;
				if (orv == '0) begin
					degen_q <= 1'b1;
					for (int k = 0; k < 3; k++) begin
						nrm_q[k] <= '0;
					end
				end else if (orv[66:23] != '0) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] >> 8;
					end
				end else if (orv[66:15] != '0) begin
					for (int k = 0; k < 3; k++) begin
						mag_q[k] <= mag_q[k] >> 1;
					end
				end
			end
			tfn_pkg::ST_SQ: begin
				acc_q <= acc_next;
				if (cnt_q == 2'd2) begin
					rad_q  <= {acc_next, 32'd0};
					root_q <= '0;
					srem_q <= '0;
				end
			end
			tfn_pkg::ST_SQRT: begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (s_ge) begin
					srem_q <= 34'(s_rem_n - s_try);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					srem_q <= s_rem_n[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			tfn_pkg::ST_DIVL: begin
				drem_q <= 32'(mm_sel) << 14;
				quo_q  <= '0;
			end
			tfn_pkg::ST_DIV: begin
				drem_q <= d_ge ? 32'(d_rem2 - {1'b0, root_q}) : d_rem2[31:0];
				quo_q  <= q_full;
				if (bit_q == 6'd1) begin
					nrm_q[cnt_q] <= neg_q[cnt_q] ? 16'(-q16) : q16;
				end
			end
			default: begin
				p1_q <= p1_q;
			end
		endcase
		// edge differences once all three corners are in
		if (state_q == tfn_pkg::ST_DIFF) begin
			for (int k = 0; k < 3; k++) begin
				d_q[k] <= comp(v1_q, k) - comp(v0_q, k);
				e_q[k] <= comp(pos_rdata, k) - comp(v0_q, k);
			end
		end
	end

endmodule

// File: src/triangle_face_normal_scatter.sv
// top level of the triangle face normal block: front end, queue, back end
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------------
//  command   | start high, busy low    | opcode, vertex_index, pos_x/y/z, corner_a/b/c
//  result    | done, one cycle only    | result_kind, normal_x/y/z, degenerate
//
// In the back end a position write uses ST_WRPOS, a normal read ST_RDN and ST_RDN2.
// A face goes through corner reads, edge differences, cross product, magnitude scaling,
// the bit-serial square root (32 steps) and the shared restoring divider; a degenerate
// face skips the square root and divide.
// After reset a clearing pass writes zero to all VERTEX_DEPTH normal entries,
// one per cycle, with busy held high throughout.
// busy is high while the two-entry command queue is full; results are never held.
module triangle_face_normal_scatter #(
	parameter int VERTEX_DEPTH     = 4096,
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        opcode,
	input  logic [tfn_pkg::IN_IDX_W-1:0]      vertex_index,
	input  logic signed [tfn_pkg::POS_W-1:0]  pos_x,
	input  logic signed [tfn_pkg::POS_W-1:0]  pos_y,
	input  logic signed [tfn_pkg::POS_W-1:0]  pos_z,
	input  logic [tfn_pkg::IN_IDX_W-1:0]      corner_a,
	input  logic [tfn_pkg::IN_IDX_W-1:0]      corner_b,
	input  logic [tfn_pkg::IN_IDX_W-1:0]      corner_c,
	output logic                              done,
	output logic                              result_kind,
	output logic signed [tfn_pkg::NRM_W-1:0]  normal_x,
	output logic signed [tfn_pkg::NRM_W-1:0]  normal_y,
	output logic signed [tfn_pkg::NRM_W-1:0]  normal_z,
	output logic                              degenerate
);

	tfn_pkg::fe_out_t  head;
	tfn_pkg::be_stat_t stat;

	// command intake and queue
	tfn_front #(.VERTEX_DEPTH(VERTEX_DEPTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.vertex_index (vertex_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.stat         (stat),
		.head         (head)
	);

	// execution
	tfn_back #(
		.VERTEX_DEPTH     (VERTEX_DEPTH),
		.NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.done        (done),
		.result_kind (result_kind),
		.normal_x    (normal_x),
		.normal_y    (normal_y),
		.normal_z    (normal_z),
		.degenerate  (degenerate)
	);

	// a degenerate face always reports a zero normal
	assert property (@(posedge clk) disable iff (!arst_n)
		done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate face with nonzero normal");

	// read results never carry the degenerate flag
	assert property (@(posedge clk) disable iff (!arst_n)
		done && result_kind == tfn_pkg::RK_READ |-> !degenerate)
		else $error("read result flagged degenerate");

	// no command transfer while the normal store is being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> busy && !done)
		else $error("activity during clearing pass");

	// result strobes never come back to back
	assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

endmodule
